// File: hdl/psa_pkg.sv
// Shared codes and field widths for the paged slot allocator.
// No dependencies; used by the top level and its checker.
package psa_pkg;

   localparam int PAGE_W  = 8;
   localparam int SLOT_W  = 6;
   localparam int COUNT_W = 7;

   localparam logic [COUNT_W-1:0] SLOTS_RESET = 7'd64;

   // request kinds carried on req_tuser
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // result status codes carried on rsp_tuser
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_PAGE  = 2'd1;
   localparam logic [1:0] ST_BAD_FREE = 2'd2;

endpackage

// File: hdl/psa_page_mem.sv
// Per-page state memory: one word per page holding link, free count and bitmap.
// Synchronous write, registered read: the word appears in the cycle after rd_en. No dependencies.
module psa_page_mem #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 79
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] page_ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         page_ram_ff[wr_addr] <= wr_data;
      end
      // hold the last read word until the next read is issued
      if (rd_en) begin
         rd_data_ff <= page_ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/paged_slot_allocator.sv
// Paged slot allocator: an allocation that creates a page or has none to create, and a
// rejected free, load the result register from the request; others read the page, then
// modify and write back. A request is taken only when idle with the result register free,
// so one read-modify-write ends before the next starts. Synchronous active-high reset sets
// idle, list head 0, page count 1, slot-count register 64, result valid 0; page memory is
// not cleared, as only pages already created are ever read.
// Depends on psa_pkg and psa_page_mem.
module paged_slot_allocator #(
   parameter int PAGES     = 256,
   parameter int MAX_SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] page_num, [13:8] slot_num, [15:14] zero
   input  logic [0:0]  req_tuser,   // [0] req_type
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] alloc_page, [13:8] alloc_slot, [15:14] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // configuration
   input  logic        csr_wen,
   input  logic [6:0]  csr_wdata    // slots_per_page
);

   // Pages that can exist: page numbers are 8 bits wide.
   localparam int PAGE_LIMIT = (PAGES < 256) ? PAGES : 256;
   localparam int AW         = $clog2(PAGE_LIMIT);
   localparam int WW         = MAX_SLOTS + psa_pkg::COUNT_W + psa_pkg::PAGE_W;

   typedef enum logic {S_IDLE, S_READ} state_type;

   state_type                     state_ff, state_in;
   logic                          op_ff, op_in;
   logic [psa_pkg::PAGE_W-1:0]    page_ff, page_in;
   logic [psa_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic [psa_pkg::PAGE_W-1:0]    free_head_ff, free_head_in;
   logic [psa_pkg::PAGE_W:0]      pages_ff, pages_in;
   logic [psa_pkg::COUNT_W-1:0]   slots_cfg_ff, slots_cfg_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [psa_pkg::PAGE_W-1:0]    rsp_page_ff, rsp_page_in;
   logic [psa_pkg::SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [1:0]                    rsp_status_ff, rsp_status_in;

   logic                          mem_wr_en, mem_rd_en;
   logic [AW-1:0]                 mem_wr_addr, mem_rd_addr;
   logic [WW-1:0]                 mem_wr_data, mem_rd_data;

   logic                          out_free, req_acc;
   logic                          in_type;
   logic [psa_pkg::PAGE_W-1:0]    in_page;
   logic [psa_pkg::SLOT_W-1:0]    in_slot;
   logic [psa_pkg::COUNT_W-1:0]   eff_slots;
   logic [MAX_SLOTS-1:0]          new_map;

   logic [psa_pkg::PAGE_W-1:0]    rd_next;
   logic [psa_pkg::COUNT_W-1:0]   rd_count, dec_count;
   logic [MAX_SLOTS-1:0]          rd_map;
   logic [MAX_SLOTS-1:0]          free_onehot, alloc_onehot;
   logic [psa_pkg::SLOT_W-1:0]    first_free;
   logic                          any_free, slot_taken;

   psa_page_mem #(
      .DEPTH (PAGE_LIMIT),
      .WIDTH (WW)
   ) u_page_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign in_type = req_tuser[0];
   assign in_page = req_tdata[7:0];
   assign in_slot = req_tdata[13:8];

   // Result register frees up this cycle if it is empty or being taken.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_acc    = req_tvalid && req_tready;

   // Clamp the configured slot count into 1..MAX_SLOTS.
   always_comb begin
      if (slots_cfg_ff == '0) begin
         eff_slots = 7'd1;
      end else if (slots_cfg_ff > 7'(MAX_SLOTS)) begin
         eff_slots = 7'(MAX_SLOTS);
      end else begin
         eff_slots = slots_cfg_ff;
      end
   end

   // Bitmap of a fresh page: slots at or above the usable count are taken,
   // and slot 0 goes to the allocation that created it.
   always_comb begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
         new_map[i] = (7'(i) >= eff_slots) || (i == 0);
      end
   end

   // Unpack the page word: {link, free count, bitmap}.
   assign rd_map   = mem_rd_data[MAX_SLOTS-1:0];
   assign rd_count = mem_rd_data[MAX_SLOTS +: psa_pkg::COUNT_W];
   assign rd_next  = mem_rd_data[MAX_SLOTS+psa_pkg::COUNT_W +: psa_pkg::PAGE_W];
   assign dec_count = rd_count - 7'd1;

   // Lowest clear bit of the bitmap.
   always_comb begin
      first_free = '0;
      for (int i = MAX_SLOTS-1; i >= 0; i--) begin
         if (!rd_map[i]) begin
            first_free = 6'(i);
         end
      end
   end
   assign any_free = !(&rd_map);

   always_comb begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
         free_onehot[i]  = (slot_ff == 6'(i));
         alloc_onehot[i] = (first_free == 6'(i));
      end
   end
   assign slot_taken = |(rd_map & free_onehot);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      page_in       = page_ff;
      slot_in       = slot_ff;
      free_head_in  = free_head_ff;
      pages_in      = pages_ff;
      slots_cfg_in  = csr_wen ? csr_wdata : slots_cfg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_page_in   = rsp_page_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = free_head_ff[AW-1:0];
      mem_wr_data   = {rd_next, dec_count, rd_map | alloc_onehot};
      mem_rd_en     = 1'b0;
      mem_rd_addr   = free_head_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               op_in   = in_type;
               page_in = in_page;
               slot_in = in_slot;
               if (in_type == psa_pkg::REQ_ALLOC) begin
                  if (free_head_ff != '0) begin
                     // fetch the head page of the free list
                     mem_rd_en = 1'b1;
                     state_in  = S_READ;
                  end else if (pages_ff >= 9'(PAGE_LIMIT)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_page_in   = '0;
                     rsp_slot_in   = '0;
                     rsp_status_in = psa_pkg::ST_NO_PAGE;
                  end else begin
                     // create the page and hand out its slot 0 in one write
                     mem_wr_en    = 1'b1;
                     mem_wr_addr  = pages_ff[AW-1:0];
                     mem_wr_data  = {free_head_ff, eff_slots - 7'd1, new_map};
                     free_head_in = (eff_slots == 7'd1) ? free_head_ff : pages_ff[7:0];
                     pages_in     = pages_ff + 9'd1;
                     rsp_valid_in  = 1'b1;
                     rsp_page_in   = pages_ff[7:0];
                     rsp_slot_in   = '0;
                     rsp_status_in = psa_pkg::ST_OK;
                  end
               end else begin
                  if (in_page == '0 || {1'b0, in_page} >= pages_ff
                      || {1'b0, in_slot} >= eff_slots) begin
                     rsp_valid_in  = 1'b1;
                     rsp_page_in   = '0;
                     rsp_slot_in   = '0;
                     rsp_status_in = psa_pkg::ST_BAD_FREE;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = in_page[AW-1:0];
                     state_in    = S_READ;
                  end
               end
            end
         end
         S_READ: begin
            // hold the fetched word until the result register can take the answer
            if (out_free) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_page_in   = '0;
               rsp_slot_in   = '0;
               rsp_status_in = psa_pkg::ST_OK;
               if (op_ff == psa_pkg::REQ_ALLOC) begin
                  if (!any_free) begin
                     // full page on the list: unlink it, nothing handed out
                     free_head_in  = rd_next;
                     rsp_status_in = psa_pkg::ST_NO_PAGE;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = free_head_ff[AW-1:0];
                     mem_wr_data = {rd_next, dec_count, rd_map | alloc_onehot};
                     if (dec_count == '0) begin
                        free_head_in = rd_next;
                     end
                     rsp_page_in = free_head_ff;
                     rsp_slot_in = first_free;
                  end
               end else begin
                  if (!slot_taken) begin
                     rsp_status_in = psa_pkg::ST_BAD_FREE;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = page_ff[AW-1:0];
                     if (rd_count == '0) begin
                        // page was full: push it back on the list head
                        mem_wr_data  = {free_head_ff, rd_count + 7'd1, rd_map & ~free_onehot};
                        free_head_in = page_ff;
                     end else begin
                        mem_wr_data  = {rd_next, rd_count + 7'd1, rd_map & ~free_onehot};
                     end
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_head_ff <= '0;
         pages_ff     <= 9'd1;
         slots_cfg_ff <= psa_pkg::SLOTS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         pages_ff     <= pages_in;
         slots_cfg_ff <= slots_cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      page_ff       <= page_in;
      slot_ff       <= slot_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_slot_ff, rsp_page_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// File: hdl/psa_checker.sv
// Port-level checker for paged_slot_allocator, attached with a bind.
// Depends on psa_pkg.
module psa_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == psa_pkg::ST_OK || rsp_tuser == psa_pkg::ST_NO_PAGE
                     || rsp_tuser == psa_pkg::ST_BAD_FREE)
      else $error("undefined status code");

   a_error_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != psa_pkg::ST_OK |-> rsp_tdata[13:0] == 14'd0)
      else $error("failed transaction reports a slot");

   a_page0_slot0: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7:0] == 8'd0 |-> rsp_tdata[13:8] == 6'd0)
      else $error("slot reported on page zero");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind paged_slot_allocator psa_checker u_psa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
